[rtl/core/rom_search_reply_parser_defines.svh]
// assertion macros shared by the rom search reply parser
`ifndef ROM_SEARCH_REPLY_PARSER_DEFINES_SVH
`define ROM_SEARCH_REPLY_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define RSP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("rsp assertion failed");

`define RSP_NEVER(lbl, cond) \
    `RSP_ASSERT(lbl, !(cond))

`else

`define RSP_ASSERT(lbl, prop)

`define RSP_NEVER(lbl, cond)

`endif

`endif

[rtl/core/rsp_pkg.sv]
// types, constants and helper functions of the rom search reply parser
`timescale 1ns / 1ps
`default_nettype none

package rsp_pkg;

    localparam logic [7:0] CR_CODE  = 8'h0D;
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // character positions within a record
    localparam logic [4:0] POS_ID_END  = 5'd16;
    localparam logic [4:0] POS_CHK_END = 5'd18;

    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_END      = 3'd1;
    localparam logic [2:0] ST_CHECKSUM = 3'd2;
    localparam logic [2:0] ST_FORMAT   = 3'd3;
    localparam logic [2:0] ST_CRC      = 3'd4;
    localparam logic [2:0] ST_FAMILY   = 3'd5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;

    typedef struct packed {
        logic [63:0] rom_id;
        logic [2:0]  status;
        logic        last;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef logic [7:0] t_crc_tab [64];

    // crc8 contribution of each single id bit, bits taken low byte first
    function automatic t_crc_tab build_crc_tab();
        t_crc_tab   tab;
        logic [7:0] crc;
        for (int k = 0; k < 64; k++) begin
            crc = CRC_POLY;
            for (int s = k + 1; s < 64; s++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
            tab[k] = crc;
        end
        return tab;
    endfunction

    localparam t_crc_tab CRC_BIT_TAB = build_crc_tab();

    // bit 4 set marks a character that is not a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b0, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b0, 4'(c - 8'h57)};
        end else begin
            res = 5'h10;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/rsp_front.sv]
// front end: accepts reply bytes, tracks the record and classifies each item
`timescale 1ns / 1ps
`default_nettype none

`include "rom_search_reply_parser_defines.svh"

module rsp_front
    import rsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_restart,
    output logic             o_ready,
    input  wire t_q_stat     i_q_stat,
    output logic             o_push,
    output t_result          o_result
);

    logic        r_mode;
    logic [4:0]  r_pos;
    logic [63:0] r_id;
    logic [7:0]  r_sum;
    logic [7:0]  r_rcv;
    logic [7:0]  r_crc;
    logic        r_lock;

    logic [4:0]  n_pos;
    logic [63:0] n_id;
    logic [7:0]  n_sum;
    logic [7:0]  n_rcv;
    logic [7:0]  n_crc;
    logic        n_lock;

    logic [4:0]  eff_pos;
    logic [63:0] eff_id;
    logic [7:0]  eff_sum;
    logic [7:0]  eff_rcv;
    logic [7:0]  eff_crc;
    logic        eff_lock;

    logic        accept;
    logic [4:0]  hexd;
    logic [4:0]  end_pos;
    logic [5:0]  base_idx;
    logic [7:0]  crc_contrib;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign hexd    = hex_decode(i_rx_byte);
    assign end_pos = r_mode ? POS_CHK_END : POS_ID_END;

    // restart clears the record and the lock before the byte is looked at
    always_comb begin
        eff_pos  = i_restart ? 5'd0  : r_pos;
        eff_id   = i_restart ? 64'd0 : r_id;
        eff_sum  = i_restart ? 8'd0  : r_sum;
        eff_rcv  = i_restart ? 8'd0  : r_rcv;
        eff_crc  = i_restart ? 8'd0  : r_crc;
        eff_lock = i_restart ? 1'b0  : r_lock;
    end

    // digit at position p lands in id bits 4*(15-p) upwards once all 16 are in
    always_comb begin
        base_idx    = {~eff_pos[3:0], 2'b00};
        crc_contrib = 8'd0;
        for (int j = 0; j < 4; j++) begin
            if (hexd[j]) begin
                crc_contrib = crc_contrib ^ CRC_BIT_TAB[base_idx | 6'(j)];
            end
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_id     = r_id;
        n_sum    = r_sum;
        n_rcv    = r_rcv;
        n_crc    = r_crc;
        n_lock   = r_lock;
        o_push   = 1'b0;
        o_result = '{rom_id: 64'd0, status: ST_FOUND, last: 1'b0};
        if (accept) begin
            n_pos  = eff_pos;
            n_id   = eff_id;
            n_sum  = eff_sum;
            n_rcv  = eff_rcv;
            n_crc  = eff_crc;
            n_lock = eff_lock;
            if (!eff_lock) begin
                if (eff_pos == 5'd0 && i_rx_byte == CR_CODE) begin
                    o_push          = 1'b1;
                    o_result.status = ST_END;
                    o_result.last   = 1'b1;
                end else if (eff_pos < POS_ID_END) begin
                    if (hexd[4]) begin
                        o_push          = 1'b1;
                        o_result.status = ST_FORMAT;
                        o_result.last   = 1'b1;
                    end else begin
                        n_id  = {eff_id[59:0], hexd[3:0]};
                        n_sum = eff_sum + i_rx_byte;
                        n_crc = eff_crc ^ crc_contrib;
                        n_pos = eff_pos + 5'd1;
                    end
                end else if (eff_pos == end_pos) begin
                    o_push = 1'b1;
                    o_result.rom_id = eff_id;
                    o_result.last   = 1'b1;
                    if (i_rx_byte != CR_CODE) begin
                        o_result.rom_id = 64'd0;
                        o_result.status = ST_FORMAT;
                    end else if (r_mode && eff_rcv != eff_sum) begin
                        o_result.status = ST_CHECKSUM;
                    end else if (eff_crc != 8'd0) begin
                        o_result.status = ST_CRC;
                    end else if (eff_id[7:0] == 8'd0) begin
                        o_result.status = ST_FAMILY;
                    end else begin
                        o_result.status = ST_FOUND;
                        o_result.last   = 1'b0;
                        n_pos = 5'd0;
                        n_id  = 64'd0;
                        n_sum = 8'd0;
                        n_rcv = 8'd0;
                        n_crc = 8'd0;
                    end
                end else if (eff_pos < end_pos) begin
                    if (hexd[4]) begin
                        o_push          = 1'b1;
                        o_result.status = ST_FORMAT;
                        o_result.last   = 1'b1;
                    end else begin
                        n_rcv = {eff_rcv[3:0], hexd[3:0]};
                        n_pos = eff_pos + 5'd1;
                    end
                end else begin
                    // checksum mode dropped mid-record
                    o_push          = 1'b1;
                    o_result.status = ST_FORMAT;
                    o_result.last   = 1'b1;
                end
                if (o_push && o_result.last) begin
                    n_lock = 1'b1;
                    n_pos  = 5'd0;
                    n_id   = 64'd0;
                    n_sum  = 8'd0;
                    n_rcv  = 8'd0;
                    n_crc  = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_pos  <= 5'd0;
            r_id   <= 64'd0;
            r_sum  <= 8'd0;
            r_rcv  <= 8'd0;
            r_crc  <= 8'd0;
            r_lock <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            r_pos  <= n_pos;
            r_id   <= n_id;
            r_sum  <= n_sum;
            r_rcv  <= n_rcv;
            r_crc  <= n_crc;
            r_lock <= n_lock;
        end
    end

    `RSP_ASSERT(a_pos_in_record, r_pos <= POS_CHK_END)
    `RSP_ASSERT(a_last_locks, (o_push && o_result.last) |=> r_lock)
    `RSP_NEVER(a_no_push_when_full, o_push && i_q_stat.full)

endmodule

`default_nettype wire

[rtl/core/rsp_queue.sv]
// short result queue between the front end and the output stage
`timescale 1ns / 1ps
`default_nettype none

`include "rom_search_reply_parser_defines.svh"

module rsp_queue
    import rsp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_pop,
    output t_result      o_head,
    output t_q_stat      o_stat
);

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    logic                do_push;
    logic                do_pop;

    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `RSP_ASSERT(a_count_bound, r_count <= QCNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

[rtl/core/rsp_back.sv]
// output stage: takes results from the queue and holds them for the sink
`timescale 1ns / 1ps
`default_nettype none

module rsp_back
    import rsp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_stat i_q_stat,
    input  wire t_result i_head,
    output logic         o_pop,
    output logic         o_valid,
    output t_result      o_result,
    input  wire logic    i_ready
);

    logic    r_valid;
    t_result r_result;

    // refill whenever the stage is empty or its item is being taken
    assign o_pop    = !i_q_stat.empty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[rtl/core/rom_search_reply_parser.sv]
// top level of the rom search reply parser
`timescale 1ns / 1ps
`default_nettype none

// Parses the ASCII reply of a device search one byte per item: each record is
// 16 hex characters, two more checksum characters when checksum mode is set,
// then CR, and yields the 64-bit ROM id (family code in the low byte) with a
// status code; a CR at record start ends the directory, and after the end or
// any error bytes are dropped until an item flagged restart. One byte is taken
// every cycle while the result queue is not full; the parser state, character sum
// and CRC8 are all updated in that single cycle by the front end, the CRC being
// built up per hex digit. A result goes from the front end through the result
// queue into the output register; the input only stalls once the two-entry result
// queue is full behind a stalled sink.
module rom_search_reply_parser
    import rsp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic                   i_cfg_wr_data,   // checksum_mode
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,       // [7:0] rx_byte
    input  wire logic                   i_s_tuser,       // [0] restart
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,       // [63:0] rom_id, [66:64] status
    output logic                        o_m_tlast
);

    t_q_stat q_stat;
    logic    push;
    logic    pop;
    t_result front_result;
    t_result head;
    t_result out_result;

    rsp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_tvalid),
        .i_rx_byte     (i_s_tdata[7:0]),
        .i_restart     (i_s_tuser),
        .o_ready       (o_s_tready),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_result      (front_result)
    );

    rsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_result),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    rsp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .o_result (out_result),
        .i_ready  (i_m_tready)
    );

    assign o_m_tdata = {5'd0, out_result.status, out_result.rom_id};
    assign o_m_tlast = out_result.last;

endmodule

`default_nettype wire

[tb/rsp_tb_pkg.sv]
// scoreboard and character helpers for the rom search reply parser testbench
`timescale 1ns / 1ps

package rsp_tb_pkg;

    import rsp_pkg::*;

    // characters just outside the hex digit ranges, plus 8'h00 and 8'hFF
    localparam logic [7:0] HEX_EDGE_NEIGHBOURS [8] = '{
        8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF
    };

    // value of a hex digit, 5'h10 for anything else
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]}) begin
            return {1'b0, c[3:0]};
        end
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10) begin
            return 8'h30 + 8'(v);
        end
        return (lower ? 8'h57 : 8'h37) + 8'(v);
    endfunction

    // reflected crc8 over the lowest nbytes bytes, low byte first
    function automatic logic [7:0] crc8_low_bytes(input logic [63:0] v, input int nbytes);
        logic [7:0] crc;
        logic [7:0] b;
        logic       mix;
        crc = 8'h00;
        for (int i = 0; i < nbytes; i++) begin
            b = v[8*i +: 8];
            for (int k = 0; k < 8; k++) begin
                mix = crc[0] ^ b[0];
                crc = crc >> 1;
                if (mix) begin
                    crc = crc ^ CRC_POLY;
                end
                b = b >> 1;
            end
        end
        return crc;
    endfunction

    class rom_reply_scoreboard;
        bit          checksum_mode;
        logic [4:0]  char_pos;
        logic [63:0] id_acc;
        logic [7:0]  char_sum;
        logic [7:0]  rx_check;
        bit          locked;
        t_result     pending_records [$];
        int          errors;
        int          live_items;

        function new();
            checksum_mode = 1'b1;
            clear_record();
            locked     = 1'b0;
            errors     = 0;
            live_items = 0;
        endfunction

        function void clear_record();
            char_pos = '0;
            id_acc   = '0;
            char_sum = '0;
            rx_check = '0;
        endfunction

        function int pending();
            return pending_records.size();
        endfunction

        // advance the parser by one accepted byte and queue any record it yields
        function void note_byte(input logic [7:0] c, input logic restart);
            logic [4:0] nib;
            logic [4:0] rec_end;
            t_result    rec;
            bit         emits;
            if (restart) begin
                clear_record();
                locked = 1'b0;
            end
            if (locked) begin
                return;
            end
            live_items++;
            nib        = nibble_of(c);
            rec_end    = checksum_mode ? POS_CHK_END : POS_ID_END;
            emits      = 1'b1;
            rec.rom_id = '0;
            rec.status = ST_FORMAT;
            rec.last   = 1'b1;
            if (char_pos == 5'd0 && c == CR_CODE) begin
                rec.status = ST_END;
            end else if (char_pos < POS_ID_END) begin
                if (!nib[4]) begin
                    id_acc   = {id_acc[59:0], nib[3:0]};
                    char_sum = char_sum + c;
                    char_pos = char_pos + 5'd1;
                    emits    = 1'b0;
                end
            end else if (char_pos == rec_end) begin
                if (c == CR_CODE) begin
                    rec.rom_id = id_acc;
                    if (checksum_mode && rx_check != char_sum) begin
                        rec.status = ST_CHECKSUM;
                    end else if (crc8_low_bytes(id_acc, 8) != 8'h00) begin
                        rec.status = ST_CRC;
                    end else if (id_acc[7:0] == 8'h00) begin
                        rec.status = ST_FAMILY;
                    end else begin
                        rec.status = ST_FOUND;
                        rec.last   = 1'b0;
                    end
                end
            end else if (char_pos < rec_end) begin
                if (!nib[4]) begin
                    rx_check = {rx_check[3:0], nib[3:0]};
                    char_pos = char_pos + 5'd1;
                    emits    = 1'b0;
                end
            end
            // anything past the record end falls through as a format error
            if (emits) begin
                pending_records.push_back(rec);
                clear_record();
                if (rec.last) begin
                    locked = 1'b1;
                end
            end
        endfunction

        function void check_result(input logic [OUT_TDATA_W-1:0] tdata, input logic tlast);
            t_result want;
            if (pending_records.size() == 0) begin
                $display("%0t: unexpected record: rom_id=%h status=%0d last=%b",
                         $time, tdata[63:0], tdata[66:64], tlast);
                errors++;
                return;
            end
            want = pending_records.pop_front();
            if (tdata[63:0] !== want.rom_id) begin
                $display("%0t: rom_id mismatch: expected %h, actual %h",
                         $time, want.rom_id, tdata[63:0]);
                errors++;
            end
            if (tdata[66:64] !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, tdata[66:64]);
                errors++;
            end
            if (tlast !== want.last) begin
                $display("%0t: last mismatch: expected %b, actual %b",
                         $time, want.last, tlast);
                errors++;
            end
            if (tdata[OUT_TDATA_W-1:67] !== '0) begin
                $display("%0t: tdata padding mismatch: expected 0, actual %h",
                         $time, tdata[OUT_TDATA_W-1:67]);
                errors++;
            end
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
// top of the rom search reply parser testbench: stimulus, handshakes and final verdict
`timescale 1ns / 1ps

module tb_top;

    import rsp_pkg::*;
    import rsp_tb_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 200;

    typedef enum int {
        REC_GOOD,
        REC_BAD_SUM,
        REC_BAD_CRC,
        REC_ZERO_FAMILY,
        REC_BAD_ID_CHAR,
        REC_BAD_CHECK_CHAR,
        REC_NO_CR,
        REC_TRUNCATED
    } rec_kind_e;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic                   i_cfg_wr_data;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;      // [7:0] rx_byte
    logic                   i_s_tuser;      // [0] restart
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;      // [63:0] rom_id, [66:64] status
    logic                   o_m_tlast;

    rom_reply_scoreboard sb;
    int                  cycle_count;
    int                  bytes_sent;

    rom_search_reply_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sink stalls at random, never during its calm window
    always @(negedge i_clk) begin
        i_m_tready <= (cycle_count >= 700 && cycle_count < 1000) ||
                      ($urandom_range(99) >= 12);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** rom_search_reply_parser: FAILED **");
            $finish;
        end else if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata, o_m_tlast);
        end
    end

    task automatic send_byte(input logic [7:0] c, input bit rs);
        @(negedge i_clk);
        while (!(bytes_sent >= 500 && bytes_sent < 700) && $urandom_range(99) < 12) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tuser  <= rs;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_byte(c, rs);
        bytes_sent++;
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit m);
        drain_and_settle();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.checksum_mode = m;
    endtask

    // one record of the given kind, built for the current checksum mode
    task automatic send_record(input rec_kind_e kind, input bit rs);
        logic [63:0] id;
        logic [7:0]  sum;
        logic [7:0]  chk;
        logic [7:0]  c;
        logic [7:0]  chars [$];
        int          flip;
        int          count;
        id = {8'h00, 24'($urandom), 32'($urandom)};
        if ($urandom_range(7) == 0) begin
            id[55:0] = '1;
        end
        if (kind == REC_ZERO_FAMILY) begin
            id[7:0] = 8'h00;
        end else if (id[7:0] == 8'h00) begin
            id[7:0] = 8'h01;
        end
        id[63:56] = crc8_low_bytes(id, 7);
        if (kind == REC_BAD_CRC) begin
            flip     = $urandom_range(63);
            id[flip] = ~id[flip];
        end
        sum = 8'h00;
        for (int i = 15; i >= 0; i--) begin
            c   = hex_char(id[4*i +: 4], $urandom_range(1));
            sum = sum + c;
            chars.push_back(c);
        end
        if (sb.checksum_mode) begin
            chk = (kind == REC_BAD_SUM) ? sum + 8'($urandom_range(1, 255)) : sum;
            chars.push_back(hex_char(chk[7:4], $urandom_range(1)));
            chars.push_back(hex_char(chk[3:0], $urandom_range(1)));
        end
        if (kind == REC_NO_CR) begin
            do c = 8'($urandom); while (c == CR_CODE);
            chars.push_back(c);
        end else begin
            chars.push_back(CR_CODE);
        end
        if (kind == REC_BAD_ID_CHAR || (kind == REC_BAD_CHECK_CHAR && sb.checksum_mode)) begin
            do begin
                c = $urandom_range(1) ? HEX_EDGE_NEIGHBOURS[$urandom_range(7)] : 8'($urandom);
            end while (nibble_of(c) < 5'h10);
            chars[(kind == REC_BAD_ID_CHAR) ? $urandom_range(15) : 16 + $urandom_range(1)] = c;
        end
        count = chars.size();
        if (kind == REC_TRUNCATED) begin
            count = $urandom_range(1, count - 1);
        end
        for (int i = 0; i < count; i++) begin
            send_byte(chars[i], rs && i == 0);
        end
    endtask

    // a whole reply: some records, then end of directory or the first faulty record
    task automatic send_reply();
        int        nrec;
        rec_kind_e kind;
        bit        first;
        nrec  = $urandom_range(4);
        first = 1'b1;
        for (int i = 0; i < nrec; i++) begin
            kind = ($urandom_range(99) < 78) ? REC_GOOD : rec_kind_e'($urandom_range(1, 7));
            send_record(kind, first);
            first = 1'b0;
            if (kind != REC_GOOD) begin
                // bytes after an error are dropped by the parser
                if (kind != REC_TRUNCATED) begin
                    repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
                end
                return;
            end
        end
        send_byte(CR_CODE, first);
    endtask

    initial begin
        int prefix_len;
        bit next_mode;
        sb            = new();
        cycle_count   = 0;
        bytes_sent    = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = 1'b0;
        i_m_tready    = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // bare end of directory, a locked byte, a bad first digit, one good record and end of directory
        send_byte(CR_CODE, 1'b1);
        send_byte(8'h78, 1'b0);
        send_byte(8'h47, 1'b1);
        send_record(REC_GOOD, 1'b1);
        send_byte(CR_CODE, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            while (sb.live_items < (phase + 1) * PHASE_ITEMS) begin
                if ($urandom_range(19) == 0) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte($urandom_range(3) == 0 ? CR_CODE : 8'($urandom),
                                  $urandom_range(3) == 0);
                    end
                end else begin
                    send_reply();
                end
            end
            if (phase < PHASES - 1) begin
                // leave a record half done across the mode change
                next_mode  = ~sb.checksum_mode;
                prefix_len = $urandom_range(1) ? 16 + (sb.checksum_mode ? $urandom_range(1) : 0)
                                               : $urandom_range(1, 15);
                for (int i = 0; i < prefix_len; i++) begin
                    send_byte(hex_char(4'($urandom), $urandom_range(1)), i == 0);
                end
                write_mode(next_mode);
                repeat ($urandom_range(1, 3)) begin
                    send_byte($urandom_range(1) ? CR_CODE
                                                : hex_char(4'($urandom), $urandom_range(1)),
                              1'b0);
                end
            end
        end

        drain_and_settle();
        if (sb.errors == 0) begin
            $display("** rom_search_reply_parser: PASSED **");
        end else begin
            $display("** rom_search_reply_parser: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/rsp_pkg.sv
rtl/core/rsp_front.sv
rtl/core/rsp_queue.sv
rtl/core/rsp_back.sv
rtl/core/rom_search_reply_parser.sv
tb/rsp_tb_pkg.sv
tb/tb_top.sv
